### src/nfb_pkg.sv
// ----------------------------------------------------------------------------
// nfb_pkg
// Shared types, constants and digit helpers for the nixie frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package nfb_pkg;

	localparam int NumDigits = 6;
	localparam int NumPoints = 3;
	localparam int FrameW    = 64;
	localparam int FrameIdxW = $clog2(FrameW);
	localparam int PointLsb  = 1;

	localparam logic [3:0] DigitMax = 4'd9;

	typedef logic [3:0]                 digit_t;
	typedef digit_t [NumDigits-1:0]     digit_arr_t;
	typedef logic [NumPoints-1:0]       point_arr_t;
	typedef logic [FrameW-1:0]          frame_t;
	typedef logic [FrameIdxW-1:0]       frame_idx_t;

	// Lowest cathode bit of each digit: tube1 tens first, tube3 ones last.
	localparam frame_idx_t DigitBase [NumDigits] = '{
		FrameIdxW'(54), FrameIdxW'(44), FrameIdxW'(34),
		FrameIdxW'(24), FrameIdxW'(14), FrameIdxW'(4)
	};

	typedef enum logic {
		ACT_SHOW    = 1'b0,
		ACT_REFRESH = 1'b1
	} action_t;

	// Per-cycle commands into the digit state.
	typedef struct packed {
		logic show;
		logic refresh;
		logic cfg_we;
		logic cfg_roll;
	} nfb_ctl_t;

	// Status back from the digit state.
	typedef struct packed {
		logic pending;
		logic more;
	} nfb_stat_t;

	function automatic digit_t clamp_digit(input digit_t d);
		return (d > DigitMax) ? DigitMax : d;
	endfunction

	function automatic digit_t next_digit(input digit_t d);
		return (d >= DigitMax) ? 4'd0 : d + 4'd1;
	endfunction

endpackage

`default_nettype wire

### src/nfb_ifs.sv
// ----------------------------------------------------------------------------
// nfb_ifs
// Valid/ready channel interfaces: input items, result frames, config writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface nfb_item_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [3:0] tube1_tens;
	logic [3:0] tube1_ones;
	logic [3:0] tube2_tens;
	logic [3:0] tube2_ones;
	logic [3:0] tube3_tens;
	logic [3:0] tube3_ones;
	logic       point1_on;
	logic       point2_on;
	logic       point3_on;

	modport source (
		output valid, action, tube1_tens, tube1_ones, tube2_tens, tube2_ones,
		       tube3_tens, tube3_ones, point1_on, point2_on, point3_on,
		input  ready
	);
	modport sink (
		input  valid, action, tube1_tens, tube1_ones, tube2_tens, tube2_ones,
		       tube3_tens, tube3_ones, point1_on, point2_on, point3_on,
		output ready
	);
endinterface

interface nfb_result_if;
	logic        valid;
	logic        ready;
	logic [63:0] frame;
	logic        still_rolling;

	modport source (output valid, frame, still_rolling, input ready);
	modport sink   (input valid, frame, still_rolling, output ready);
endinterface

interface nfb_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

### src/nfb_digit_state.sv
// ----------------------------------------------------------------------------
// nfb_digit_state
// Target and shown digits, points, refresh pending flag and roll enable.
// ----------------------------------------------------------------------------
`default_nettype none

module nfb_digit_state import nfb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  nfb_ctl_t   ctl,
	input  digit_arr_t show_digits,
	input  point_arr_t show_points,
	output digit_arr_t shown,
	output point_arr_t points,
	output nfb_stat_t  stat
);

	digit_arr_t           target_q;
	digit_arr_t           shown_q;
	point_arr_t           points_q;
	logic                 pending_q;
	logic                 roll_q;

	digit_arr_t           clamped;
	digit_arr_t           shown_on_show;
	digit_arr_t           shown_on_refresh;
	logic [NumDigits-1:0] differ;

	always_comb begin
		for (int i = 0; i < NumDigits; i++) begin
			clamped[i] = clamp_digit(show_digits[i]);
			differ[i]  = (shown_q[i] != target_q[i]);
			// with rolling, a changed digit restarts one past its new target
			if (roll_q) begin
				shown_on_show[i] = (clamped[i] != target_q[i]) ?
					next_digit(clamped[i]) : shown_q[i];
			end else begin
				shown_on_show[i] = clamped[i];
			end
			shown_on_refresh[i] = differ[i] ? next_digit(shown_q[i]) : shown_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= '0;
			shown_q   <= '0;
			points_q  <= '0;
			pending_q <= 1'b1;
			roll_q    <= 1'b0;
		end else begin
			if (ctl.cfg_we) begin
				roll_q <= ctl.cfg_roll;
			end
			if (ctl.show) begin
				target_q  <= clamped;
				shown_q   <= shown_on_show;
				points_q  <= show_points;
				pending_q <= 1'b1;
			end else if (ctl.refresh) begin
				shown_q   <= shown_on_refresh;
				pending_q <= |differ;
			end
		end
	end

	assign shown        = shown_q;
	assign points       = points_q;
	assign stat.pending = pending_q;
	assign stat.more    = |differ;

endmodule

`default_nettype wire

### src/nfb_frame_enc.sv
// ----------------------------------------------------------------------------
// nfb_frame_enc
// One-hot cathode decode of six digits plus the three point bits.
// ----------------------------------------------------------------------------
`default_nettype none

module nfb_frame_enc import nfb_pkg::*; (
	input  digit_arr_t shown,
	input  point_arr_t points,
	output frame_t     frame
);

	always_comb begin
		frame = '0;
		for (int i = 0; i < NumDigits; i++) begin
			frame[DigitBase[i] + FrameIdxW'(clamp_digit(shown[i]))] = 1'b1;
		end
		frame[PointLsb +: NumPoints] = points;
	end

endmodule

`default_nettype wire

### src/nixie_frame_builder_with_digit_roll.sv
// ----------------------------------------------------------------------------
// nixie_frame_builder_with_digit_roll
// Builds one-hot nixie frames from shown digits and rolls digits to target.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                   | transfer when
//  item    | in  | action, tube1..3 tens/ones, point1..3_on  | valid & ready
//  result  | out | frame[63:0], still_rolling                | valid & ready
//  cfg     | in  | data = roll_enable                        | valid & ready
//
//  One item per cycle while item.ready is high; a refresh result appears
//  in the output register the cycle after its transfer.
//  item.ready drops only while the output register is full and stalled.
//  cfg is always ready; a write takes effect from the next cycle.
//  Reset: digits and points zero, rolling off, a refresh pending.
// ----------------------------------------------------------------------------
`default_nettype none

module nixie_frame_builder_with_digit_roll import nfb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	nfb_item_if.sink         item,
	nfb_result_if.source     result,
	nfb_cfg_if.sink          cfg
);

	nfb_ctl_t   ctl;
	nfb_stat_t  stat;
	digit_arr_t show_digits;
	point_arr_t show_points;
	digit_arr_t shown;
	point_arr_t points;
	frame_t     frame_d;

	logic       item_xfer;
	logic       emit;

	logic       out_valid_q;
	frame_t     frame_q;
	logic       still_q;

	assign item.ready = !out_valid_q || result.ready;
	assign cfg.ready  = 1'b1;
	assign item_xfer  = item.valid && item.ready;

	assign show_digits = {item.tube3_ones, item.tube3_tens, item.tube2_ones,
	                      item.tube2_tens, item.tube1_ones, item.tube1_tens};
	assign show_points = {item.point3_on, item.point2_on, item.point1_on};

	// a refresh with nothing pending is swallowed
	assign emit = item_xfer && (action_t'(item.action) == ACT_REFRESH) && stat.pending;

	assign ctl.show     = item_xfer && (action_t'(item.action) == ACT_SHOW);
	assign ctl.refresh  = emit;
	assign ctl.cfg_we   = cfg.valid;
	assign ctl.cfg_roll = cfg.data;

	nfb_digit_state u_state (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.show_digits (show_digits),
		.show_points (show_points),
		.shown       (shown),
		.points      (points),
		.stat        (stat)
	);

	nfb_frame_enc u_enc (
		.shown  (shown),
		.points (points),
		.frame  (frame_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item.ready) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			frame_q <= frame_d;
			still_q <= stat.more;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.frame         = frame_q;
	assign result.still_rolling = still_q;

endmodule

`default_nettype wire

### src/nfb_checker.sv
// ----------------------------------------------------------------------------
// nfb_checker
// Port-level checks on the frame builder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nfb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [63:0] res_frame
);

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_frame))
		else $error("result changed while stalled");

	// each digit field lights exactly one cathode, bit 0 never set
	a_frame_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $onehot(res_frame[63:54]) && $onehot(res_frame[53:44]) &&
		              $onehot(res_frame[43:34]) && $onehot(res_frame[33:24]) &&
		              $onehot(res_frame[23:14]) && $onehot(res_frame[13:4]) &&
		              !res_frame[0])
		else $error("frame digit field not one-hot");

	// input backpressure only from a stalled full output register
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> res_valid && !res_ready)
		else $error("item stalled without output stall");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !res_valid)
		else $error("result valid during reset");

endmodule

bind nixie_frame_builder_with_digit_roll nfb_checker u_nfb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_ready (item.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_frame  (result.frame)
);

`default_nettype wire
